@@ design/lds_pkg.sv @@
`default_nettype none
package lds_pkg;

  localparam int unsigned MaxDegreeDef = 128;
  localparam int unsigned AddrW = 10;
  localparam int unsigned ValueW = 31;
  localparam int unsigned DegreeW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ValueW-1:0] SeedReset = 31'd2067261;
  localparam logic [DegreeW-1:0] CountReset = 8'd100;
  localparam logic [31:0] PmModulus = 32'h7FFF_FFFF;
  localparam logic [14:0] PmMult = 15'd16807;

  localparam logic [CfgIdxW-1:0] CfgSeed = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDegreeCount = 2'd1;

  localparam logic ActWrite = 1'b0;
  localparam logic ActDraw = 1'b1;

  typedef enum logic {
    KindWrite,
    KindDraw
  } item_kind_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackFold,
    BackScan
  } back_state_e;

  typedef struct packed {
    item_kind_e kind;
    logic [AddrW-1:0] addr;
    logic [ValueW-1:0] value;
  } item_t;

endpackage
`default_nettype wire

@@ design/lds_front.sv @@
`default_nettype none
module lds_front #(
  parameter int unsigned MaxDegree = lds_pkg::MaxDegreeDef
) (
  input  wire logic                          start_i,
  input  wire logic                          action_i,
  input  wire logic [lds_pkg::DegreeW-1:0]   entry_index_i,
  input  wire logic [lds_pkg::ValueW-1:0]    entry_value_i,
  input  wire logic                          q_full_i,
  output logic                               busy_o,
  output logic                               push_o,
  output lds_pkg::item_t                     item_o
);

  logic accept;
  logic index_ok;

  assign busy_o = q_full_i;
  assign accept = start_i && !q_full_i;
  assign index_ok = (entry_index_i != '0) && (32'(entry_index_i) <= 32'(MaxDegree));

  always_comb begin
    item_o.value = entry_value_i;
    item_o.addr = lds_pkg::AddrW'(entry_index_i - 8'd1);
    if (action_i == lds_pkg::ActDraw) begin
      item_o.kind = lds_pkg::KindDraw;
      push_o = accept;
    end else begin
      // writes to a degree outside the table are dropped here
      item_o.kind = lds_pkg::KindWrite;
      push_o = accept && index_ok;
    end
  end

endmodule
`default_nettype wire

@@ design/lds_queue.sv @@
`default_nettype none
module lds_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lds_pkg::item_t item_i,
  input  wire logic           pop_i,
  output lds_pkg::item_t      item_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PtrW = $clog2(lds_pkg::QueueDepth);

  lds_pkg::item_t slot_q [lds_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o = (32'(count_q) == 32'(lds_pkg::QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ design/lds_back.sv @@
`default_nettype none
module lds_back #(
  parameter int unsigned MaxDegree = lds_pkg::MaxDegreeDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          seed_load_i,
  input  wire logic [lds_pkg::ValueW-1:0]    seed_i,
  input  wire logic [lds_pkg::DegreeW-1:0]   count_i,
  input  wire lds_pkg::item_t                item_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               valid_o,
  output logic [lds_pkg::DegreeW-1:0]        degree_o,
  output logic [lds_pkg::ValueW-1:0]         random_value_o
);

  localparam int unsigned AW = $clog2(MaxDegree);

  lds_pkg::back_state_e state_q, state_d;
  logic [lds_pkg::ValueW-1:0] gen_q, gen_d;
  logic [45:0] prod_q;
  logic [31:0] fold_sum;
  logic [lds_pkg::ValueW-1:0] fold_val;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] rd_addr;
  logic [lds_pkg::ValueW-1:0] thr_mem_q [MaxDegree];
  logic [lds_pkg::ValueW-1:0] rd_q;
  logic hit, last;
  logic valid_d;
  logic [lds_pkg::DegreeW-1:0] degree_d;
  logic mem_we;

  // mod 2^31-1: fold the high part onto the low part, then one subtract
  assign fold_sum = {1'b0, prod_q[30:0]} + 32'(prod_q[45:31]);
  assign fold_val = (fold_sum >= lds_pkg::PmModulus) ?
                    31'(fold_sum - lds_pkg::PmModulus) : fold_sum[30:0];

  assign hit = (rd_q >= gen_q);
  assign last = (32'(k_q) + 32'd1 >= 32'(count_i));
  assign rd_addr = (state_q == lds_pkg::BackFold) ? '0 : AW'(k_q + 1'b1);

  always_comb begin
    state_d = state_q;
    gen_d = gen_q;
    k_d = k_q;
    pop_o = 1'b0;
    mem_we = 1'b0;
    valid_d = 1'b0;
    degree_d = count_i;
    case (state_q)
      lds_pkg::BackIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (item_i.kind == lds_pkg::KindDraw) begin
            state_d = lds_pkg::BackFold;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      lds_pkg::BackFold: begin
        gen_d = fold_val;
        k_d = '0;
        state_d = lds_pkg::BackScan;
      end
      lds_pkg::BackScan: begin
        if (hit || last) begin
          valid_d = 1'b1;
          degree_d = hit ? (lds_pkg::DegreeW'(k_q) + lds_pkg::DegreeW'(1)) : count_i;
          state_d = lds_pkg::BackIdle;
        end else begin
          k_d = AW'(k_q + 1'b1);
        end
      end
      default: begin
        state_d = lds_pkg::BackIdle;
      end
    endcase
    if (seed_load_i) begin
      gen_d = seed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lds_pkg::BackIdle;
      gen_q <= lds_pkg::SeedReset;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      gen_q <= gen_d;
      valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    prod_q <= gen_q * lds_pkg::PmMult;
    if (valid_d) begin
      degree_o <= degree_d;
      random_value_o <= gen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      thr_mem_q[item_i.addr[AW-1:0]] <= item_i.value;
    end
    rd_q <= thr_mem_q[rd_addr];
  end

endmodule
`default_nettype wire

@@ design/lt_degree_sampler_unit.sv @@
// channel    | handshake                   | beat
// -----------+-----------------------------+----------------------------------------
// command    | start high, busy low        | action_i, entry_index_i, entry_value_i
// result     | valid_o high for one cycle  | degree_o, random_value_o
// config     | cfg_valid_i and cfg_ready_o | cfg_index_i, cfg_data_i
//
// a table write is done as the back end pops it; a draw folds the generator, then
// scans up to the returned degree (at most the degree count), one table entry scanned
// per cycle through the single read port of the threshold memory
// commands are taken while the two-entry queue has room; busy is a full queue
// reset clears control and loads the generator; the table is undefined until written
// the receiver cannot stall: each result is shown for one cycle only
`default_nettype none
module lt_degree_sampler_unit #(
  parameter int unsigned MaxDegree = lds_pkg::MaxDegreeDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          action_i,
  input  wire logic [lds_pkg::DegreeW-1:0]   entry_index_i,
  input  wire logic [lds_pkg::ValueW-1:0]    entry_value_i,
  output logic                               valid_o,
  output logic [lds_pkg::DegreeW-1:0]        degree_o,
  output logic [lds_pkg::ValueW-1:0]         random_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lds_pkg::ValueW-1:0]    cfg_data_i
);

  logic [lds_pkg::DegreeW-1:0] degree_count_q, degree_count_d;
  logic [lds_pkg::DegreeW-1:0] eff_count;
  logic cfg_we, seed_load;
  logic q_push, q_pop, q_empty, q_full;
  lds_pkg::item_t front_item, q_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign seed_load = cfg_we && (cfg_index_i == lds_pkg::CfgSeed);

  always_comb begin
    degree_count_d = degree_count_q;
    if (cfg_we && (cfg_index_i == lds_pkg::CfgDegreeCount)) begin
      degree_count_d = cfg_data_i[lds_pkg::DegreeW-1:0];
    end
    if (degree_count_q == '0) begin
      eff_count = lds_pkg::DegreeW'(1);
    end else if (32'(degree_count_q) > 32'(MaxDegree)) begin
      eff_count = lds_pkg::DegreeW'(MaxDegree);
    end else begin
      eff_count = degree_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_count_q <= lds_pkg::CountReset;
    end else begin
      degree_count_q <= degree_count_d;
    end
  end

  lds_front #(
    .MaxDegree(MaxDegree)
  ) u_front (
    .start_i      (start),
    .action_i     (action_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .q_full_i     (q_full),
    .busy_o       (busy),
    .push_o       (q_push),
    .item_o       (front_item)
  );

  lds_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  lds_back #(
    .MaxDegree(MaxDegree)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_load_i   (seed_load),
    .seed_i        (cfg_data_i),
    .count_i       (eff_count),
    .item_i        (q_item),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .valid_o       (valid_o),
    .degree_o      (degree_o),
    .random_value_o(random_value_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue push while full");

  a_degree_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (degree_o != '0) && (degree_o <= eff_count))
    else $error("degree outside the active range");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("results on adjacent cycles");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import lds_pkg::*;

  localparam int unsigned MaxDeg = MaxDegreeDef;
  localparam logic [ValueW-1:0] ValueMax = 31'd2147483646;
  localparam logic [ValueW-1:0] SeedStuck = 31'h7FFF_FFFF;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;
  localparam int unsigned SettleCycles = MaxDeg + 16;

  typedef struct {
    logic action;
    logic [DegreeW-1:0] index;
    logic [ValueW-1:0] value;
  } cmd_t;

  typedef struct {
    logic [DegreeW-1:0] degree;
    logic [ValueW-1:0] rand_val;
  } draw_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic action_i = ActWrite;
  logic [DegreeW-1:0] entry_index_i = '0;
  logic [ValueW-1:0] entry_value_i = '0;
  logic valid_o;
  logic [DegreeW-1:0] degree_o;
  logic [ValueW-1:0] random_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ValueW-1:0] cfg_data_i = '0;

  lt_degree_sampler_unit dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .action_i,
    .entry_index_i,
    .entry_value_i,
    .valid_o,
    .degree_o,
    .random_value_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  cmd_t pending_cmds[$];
  draw_t expected_draws[$];
  int fail_count = 0;
  bit idle_on = 1'b1;
  logic cmd_taken = 1'b0;

  // predictor state, updated at each accepted beat
  logic [ValueW-1:0] model_gen = SeedReset;
  logic [DegreeW-1:0] model_count = CountReset;
  logic [ValueW-1:0] model_tbl [1:MaxDeg];

  // stimulus planning state, runs ahead of the block
  logic [ValueW-1:0] plan_gen = SeedReset;
  logic [DegreeW-1:0] plan_count = CountReset;
  logic [ValueW-1:0] plan_tbl [1:MaxDeg];
  bit plan_written [1:MaxDeg];

  function automatic logic [ValueW-1:0] pm_next(input logic [ValueW-1:0] s);
    logic [63:0] prod;
    prod = 64'(s) * 64'(PmMult);
    return ValueW'(prod % 64'(PmModulus));
  endfunction

  function automatic int unsigned eff_count(input logic [DegreeW-1:0] c);
    if (c == 0) return 1;
    if (c > MaxDeg) return MaxDeg;
    return c;
  endfunction

  function automatic logic [DegreeW-1:0] pick_degree(input logic [ValueW-1:0] r);
    int unsigned n;
    n = eff_count(model_count);
    for (int unsigned k = 1; k <= n; k++) begin
      if (model_tbl[k] >= r) return DegreeW'(k);
    end
    return DegreeW'(n);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin : driver
    cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (pending_cmds.size() == 0 || (idle_on && $urandom_range(0, 99) < 21)) begin
        start <= 1'b0;
      end else begin
        nxt = pending_cmds.pop_front();
        start <= 1'b1;
        action_i <= nxt.action;
        entry_index_i <= nxt.index;
        entry_value_i <= nxt.value;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    draw_t want;
    logic [ValueW-1:0] r;
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= start && !busy;
      if (valid_o) begin
        if (expected_draws.size() == 0) begin
          $error("unexpected result beat: degree %0d random_value %0d",
                 degree_o, random_value_o);
          fail_count++;
        end else begin
          want = expected_draws.pop_front();
          if (degree_o !== want.degree) begin
            $error("degree: expected %0d, got %0d", want.degree, degree_o);
            fail_count++;
          end
          if (random_value_o !== want.rand_val) begin
            $error("random_value: expected %0d, got %0d", want.rand_val, random_value_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (action_i == ActDraw) begin
          r = pm_next(model_gen);
          model_gen = r;
          expected_draws.push_back('{degree: pick_degree(r), rand_val: r});
        end else if (entry_index_i >= 1 && entry_index_i <= MaxDeg) begin
          model_tbl[entry_index_i] = entry_value_i;
        end
      end
    end
  end

  task automatic push_write(input logic [DegreeW-1:0] idx, input logic [ValueW-1:0] val);
    pending_cmds.push_back('{action: ActWrite, index: idx, value: val});
    if (idx >= 1 && idx <= MaxDeg) begin
      plan_tbl[idx] = val;
      plan_written[idx] = 1'b1;
    end
  endtask

  task automatic push_draw();
    pending_cmds.push_back('{action: ActDraw, index: DegreeW'($urandom()),
                             value: ValueW'($urandom())});
    plan_gen = pm_next(plan_gen);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValueW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgSeed: begin
        model_gen = data;
        plan_gen = data;
      end
      CfgDegreeCount: begin
        model_count = data[DegreeW-1:0];
        plan_count = data[DegreeW-1:0];
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic results_done();
    while (pending_cmds.size() != 0 || start || expected_draws.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic settle();
    results_done();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [ValueW-1:0] seed, input logic [ValueW-1:0] count,
                           input int n_items, input bit idle, input bit pause_mid);
    int made;
    int unsigned sel, n, k;
    logic [ValueW-1:0] r, top;
    longint unsigned prev, v;
    bit ok;
    write_reg(CfgSeed, seed);
    write_reg(CfgDegreeCount, count);
    idle_on = idle;
    made = 0;
    while (made < n_items) begin
      if (pause_mid && made >= n_items / 2) begin
        results_done();
        pause_mid = 1'b0;
      end
      sel = $urandom_range(0, 99);
      n = eff_count(plan_count);
      if (sel < 50) begin
        // draw only if the scan stays on written entries, else fill the gap
        r = pm_next(plan_gen);
        ok = 1'b0;
        for (k = 1; k <= n; k++) begin
          if (!plan_written[k]) break;
          if (plan_tbl[k] >= r) begin
            ok = 1'b1;
            break;
          end
        end
        if (ok || k > n) push_draw();
        else push_write(DegreeW'(k), $urandom_range(0, ValueMax));
        made++;
      end else if (sel < 65) begin
        // monotone cumulative table over the degrees in use
        top = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ValueMax) : ValueMax;
        prev = 0;
        for (k = 1; k <= n; k++) begin
          v = prev + $urandom_range(0, int'(2 * (top - prev) / (n - k + 1)));
          if (v > top || k == n) v = top;
          push_write(DegreeW'(k), ValueW'(v));
          prev = v;
        end
        made += n;
      end else if (sel < 85) begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = ValueMax;
          default: v = $urandom_range(0, ValueMax);
        endcase
        push_write(DegreeW'($urandom_range(1, MaxDeg)), ValueW'(v));
        made++;
      end else if (sel < 92) begin
        // ignored write outside the table
        push_write(($urandom_range(0, 1) == 0) ? DegreeW'(0)
                   : DegreeW'($urandom_range(MaxDeg + 1, 255)), ValueW'($urandom()));
      end else begin
        k = $urandom_range(0, 255);
        push_write(DegreeW'(k), ValueW'($urandom()));
        if (k >= 1 && k <= MaxDeg) made++;
      end
    end
    settle();
  endtask

  initial begin
    #4_000_000;
    $display("lt_degree_sampler_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // single degree in use, unit seed
    write_reg(CfgDegreeCount, 0);
    write_reg(CfgSeed, 1);
    push_write(1, 0);
    push_draw();
    push_write(1, ValueMax);
    push_draw();
    push_write(0, ValueMax);
    push_write(8'hFF, SeedStuck);
    push_write(MaxDeg + 1, 0);
    push_write(MaxDeg, 0);
    push_draw();
    settle();

    // count saturates, top seed
    write_reg(CfgDegreeCount, 255);
    push_draw();
    settle();
    write_reg(CfgSeed, ValueMax);
    push_draw();
    push_draw();
    settle();

    // generator stuck at zero
    write_reg(CfgSeed, 0);
    push_draw();
    push_draw();
    settle();
    write_reg(CfgSeed, SeedStuck);
    write_reg(CfgSpare2, ValueW'($urandom()));
    write_reg(CfgSpare3, ValueW'($urandom()));
    push_draw();
    settle();

    // no threshold qualifies, then exact equality
    write_reg(CfgSeed, 1);
    write_reg(CfgDegreeCount, 31'h7FFF_FF03);
    push_write(1, 0);
    push_write(2, 5);
    push_write(3, 0);
    push_draw();
    push_write(2, 16807);
    settle();
    write_reg(CfgSeed, 1);
    push_draw();
    settle();

    run_phase($urandom_range(1, ValueMax), MaxDeg, 180, 1'b0, 1'b0);
    run_phase(ValueMax, 1, 60, 1'b1, 1'b0);
    run_phase($urandom_range(1, ValueMax), $urandom_range(2, 40), 130, 1'b1, 1'b1);
    run_phase($urandom_range(1, ValueMax), $urandom_range(64, 127), 150, 1'b1, 1'b0);
    run_phase($urandom_range(1, ValueMax), $urandom_range(0, 255), 90, 1'b1, 1'b0);
    run_phase(1, $urandom_range(1, 16), 90, 1'b1, 1'b0);

    if (fail_count == 0) begin
      $display("lt_degree_sampler_unit regression: pass");
    end else begin
      $display("lt_degree_sampler_unit regression: fail");
    end
    $finish;
  end

endmodule
